### hdl/raycast_wall_column_texturer_defines.svh
// Assertion macros for the raycast wall column texturer.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define RCWT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcwt assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RCWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcwt assertion failed");
`else
`define RCWT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RCWT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/rcwt_pkg.sv
// Shared types and constants for the raycast wall column texturer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rcwt_pkg;

  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int ROW_W       = 11;
  localparam int BASE_W      = 18;

  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd600;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROUCH_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BONUS_MODE    = 3'd4;

  // Input item opcodes.
  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Result pixel kinds.
  localparam logic [1:0] KIND_CEILING = 2'd0;
  localparam logic [1:0] KIND_WALL    = 2'd1;
  localparam logic [1:0] KIND_FLOOR   = 2'd2;

  // Map cell codes with texture overrides.
  localparam logic [7:0] CELL_FIVE   = 8'h35;
  localparam logic [7:0] CELL_DOT    = 8'h2E;
  localparam logic [7:0] CELL_COMMA  = 8'h2C;
  localparam logic [7:0] CELL_UNDER  = 8'h5F;
  localparam logic [7:0] CELL_AT     = 8'h40;
  localparam logic [7:0] CELL_HASH   = 8'h23;
  localparam logic [7:0] CELL_DOLLAR = 8'h24;

  // Texture numbers.
  localparam logic [5:0] TID_NORTH  = 6'd0;
  localparam logic [5:0] TID_SOUTH  = 6'd1;
  localparam logic [5:0] TID_WEST   = 6'd2;
  localparam logic [5:0] TID_EAST   = 6'd3;
  localparam logic [5:0] TID_DOT    = 6'd33;
  localparam logic [5:0] TID_COMMA  = 6'd34;
  localparam logic [5:0] TID_UNDER  = 6'd35;
  localparam logic [5:0] TID_AT     = 6'd36;
  localparam logic [5:0] TID_HASH   = 6'd37;
  localparam logic [5:0] TID_DOLLAR = 6'd38;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIT_MUL,
    S_HIT_WB,
    S_DIV_RUN,
    S_START_WB
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/rcwt_mul.sv
// Shared signed multiplier with a registered product.
// Depends on rcwt_pkg.
`timescale 1ns / 1ps

module rcwt_mul import rcwt_pkg::*; #(
  parameter int AW = 25,
  parameter int BW = 18
) (
  input  logic                       clk,
  input  logic signed [AW-1:0]       a,
  input  logic signed [BW-1:0]       b,
  output logic signed [AW+BW-1:0]    p
);

  logic signed [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

### hdl/rcwt_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rcwt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "raycast_wall_column_texturer_defines.svh"

module rcwt_div import rcwt_pkg::*; #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output div_stat_t         stat,
  output logic [NUM_W-1:0]  quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      den_nxt  = den;
      num_nxt  = num;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

  `RCWT_ASSERT_NEXT(a_div_start_busy, clk, rst_n, rst_n && start, stat.busy)
  `RCWT_ASSERT_IMPL(a_div_done_idle, clk, rst_n, stat.done, !stat.busy)

endmodule

### hdl/raycast_wall_column_texturer.sv
// Top level of the raycast wall column texturer: setup sequencer, row generator.
// Depends on rcwt_pkg, rcwt_mul, rcwt_div and the assertion macro header.
`timescale 1ns / 1ps
`include "raycast_wall_column_texturer_defines.svh"

// Usage
// The input stream carries two kinds of item, told apart by in_tuser. A setup
// item holds one screen column's ray result; the block picks the texture, works
// out the texture column, divides for the vertical texture step and multiplies
// out the start position. A pixel item then yields one screen row, top to
// bottom: ceiling color, a wall texel coordinate, or floor color, with tlast on
// the final row. A pixel item with no active column is taken and dropped.
// Throughput: a pixel item is taken every cycle and its result appears in the output
// register in the next cycle. A setup item holds in_tready low while the sequencer
// runs the hit-point product, the one-bit-per-cycle step divider and the start
// product; the shared multiplier serves both products.
// When the receiver stalls, the output register holds its item and in_tready
// drops until it is taken. Reset clears the column and the handshake state and
// loads the register defaults (screen height 600). Configuration writes go
// through the cfg port and must only happen while the block is idle.

module raycast_wall_column_texturer import rcwt_pkg::*; #(
  parameter int TEX_SIZE = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata, lowest bit up: column, hit_side, ray_dir_x, ray_dir_y, pos_x, pos_y,
  // wall_dist, line_first, line_last, line_height, cell_code, zero fill.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: opcode.
  input  logic                   in_tuser,
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata, lowest bit up: row, out_column, texture_id, tex_u, tex_v, flat_color,
  // zero fill.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // tuser: pixel_kind.
  output logic [1:0]             out_tuser,
  // tlast: last_row.
  output logic                   out_tlast,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TEX_BITS = $clog2(TEX_SIZE);
  localparam int VSTEP_W  = TEX_BITS + 17;
  localparam int MUL_AW   = (VSTEP_W + 1 > 25) ? VSTEP_W + 1 : 25;
  localparam int MUL_PW   = MUL_AW + BASE_W;

  // Input fields.
  logic [10:0] f_column;
  logic        f_side;
  logic [15:0] f_dir_x, f_dir_y;
  logic [21:0] f_pos_x, f_pos_y;
  logic [23:0] f_dist;
  logic [10:0] f_line_first, f_line_last;
  logic [15:0] f_line_height;
  logic [7:0]  f_cell;

  assign f_column      = in_tdata[10:0];
  assign f_side        = in_tdata[11];
  assign f_dir_x       = in_tdata[27:12];
  assign f_dir_y       = in_tdata[43:28];
  assign f_pos_x       = in_tdata[65:44];
  assign f_pos_y       = in_tdata[87:66];
  assign f_dist        = in_tdata[111:88];
  assign f_line_first  = in_tdata[122:112];
  assign f_line_last   = in_tdata[133:123];
  assign f_line_height = in_tdata[149:134];
  assign f_cell        = in_tdata[157:150];

  // Configuration registers.
  logic [10:0] screen_height_r;
  logic [23:0] ceiling_color_r;
  logic [23:0] floor_color_r;
  logic [10:0] crouch_offset_r;
  logic        bonus_mode_r;

  // Column state.
  state_t                    state_r, state_nxt;
  logic                      column_active_r;
  logic [ROW_W-1:0]          row_counter_r;
  logic [10:0]               held_column_r;
  logic [5:0]                held_tid_r;
  logic [TEX_BITS-1:0]       held_tex_u_r;
  logic [10:0]               wall_first_row_r;
  logic [10:0]               wall_end_row_r;
  logic [VSTEP_W-1:0]        v_step_r;
  logic [39:0]               v_position_r;

  // Setup operands held across the sequence.
  logic [23:0]               dist_r;
  logic [15:0]               dir_r;
  logic [15:0]               pos_lo_r;
  logic                      mirror_r;
  logic [15:0]               lh_r;
  logic signed [BASE_W-1:0]  base_r;

  // Output register.
  logic                      out_valid_r;
  logic [1:0]                out_kind_r;
  logic [9:0]                out_row_r;
  logic [10:0]               out_col_r;
  logic [5:0]                out_tid_r;
  logic [5:0]                out_tu_r;
  logic [5:0]                out_tv_r;
  logic [23:0]               out_color_r;
  logic                      out_last_r;

  // Sequencer controls.
  logic                      mul_sel_start;
  logic                      div_start;
  logic                      hit_wb;
  logic                      step_wb;
  logic                      pos_wb;

  logic                      in_fire, setup_fire, pix_fire;
  logic [10:0]               h_eff;
  logic                      pix_last;
  logic [1:0]                pix_kind;
  logic [TEX_BITS-1:0]       pix_tv;
  logic [39:0]               v_neg;
  logic [15:0]               lh_eff;
  logic signed [BASE_W-1:0]  base_w;
  logic                      dx_pos, dx_neg, dy_pos, dy_neg;
  logic [5:0]                tid_w;

  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [BASE_W-1:0]  mul_b;
  logic signed [MUL_PW-1:0]  mul_p;
  logic [15:0]               frac;
  logic [TEX_BITS-1:0]       u_raw;
  div_stat_t                 div_stat;
  logic [VSTEP_W-1:0]        div_quo;

  // Effective screen height: zero acts as one row, large values clamp.
  always_comb begin
    if (screen_height_r == 11'd0) begin
      h_eff = 11'd1;
    end else if ({2'b00, screen_height_r} > 13'(MAX_ROWS)) begin
      h_eff = 11'(MAX_ROWS);
    end else begin
      h_eff = screen_height_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign setup_fire = in_fire && (in_tuser == OP_SETUP);
  assign pix_fire   = in_fire && (in_tuser == OP_PIXEL) && column_active_r;

  // Texture selection from the hit side, ray signs and the cell overrides.
  assign dx_pos = !f_dir_x[15] && (f_dir_x != 16'd0);
  assign dx_neg = f_dir_x[15];
  assign dy_pos = !f_dir_y[15] && (f_dir_y != 16'd0);
  assign dy_neg = f_dir_y[15];

  always_comb begin
    if (!f_side) begin
      tid_w = dx_pos ? TID_EAST : TID_WEST;
    end else begin
      tid_w = dy_neg ? TID_NORTH : TID_SOUTH;
    end
    if (bonus_mode_r) begin
      case (f_cell)
        CELL_FIVE:   tid_w = TID_SOUTH;
        CELL_DOT:    tid_w = TID_DOT;
        CELL_COMMA:  tid_w = TID_COMMA;
        CELL_UNDER:  tid_w = TID_UNDER;
        CELL_AT:     tid_w = TID_AT;
        CELL_HASH:   tid_w = TID_HASH;
        CELL_DOLLAR: tid_w = TID_DOLLAR;
        default: begin
          if (f_side && dy_pos) begin
            tid_w = TID_WEST;
          end
        end
      endcase
    end
  end

  // Start row offset: line_first - H/2 + line_height/2 - crouch_offset.
  assign lh_eff = (f_line_height == 16'd0) ? 16'd1 : f_line_height;
  assign base_w = $signed({7'd0, f_line_first}) - $signed({8'd0, h_eff[10:1]})
                + $signed({3'd0, lh_eff[15:1]})
                - $signed({{7{crouch_offset_r[10]}}, crouch_offset_r});

  // Shared multiplier: hit-point product first, then start position.
  always_comb begin
    if (mul_sel_start) begin
      mul_a = $signed({{(MUL_AW-VSTEP_W){1'b0}}, div_quo});
      mul_b = base_r;
    end else begin
      mul_a = $signed({{(MUL_AW-24){1'b0}}, dist_r});
      mul_b = $signed({{(BASE_W-16){dir_r[15]}}, dir_r});
    end
  end

  rcwt_mul #(
    .AW (MUL_AW),
    .BW (BASE_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Step divider: (TEX_SIZE << 16) / line_height.
  rcwt_div #(
    .NUM_W (VSTEP_W),
    .DEN_W (16)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (VSTEP_W'(TEX_SIZE) << 16),
    .den   (lh_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // Fraction of the hit point in Q.16; its top bits index the texture column.
  assign frac  = mul_p[29:14] + pos_lo_r;
  assign u_raw = frac[15 -: TEX_BITS];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (setup_fire) begin
          state_nxt = S_HIT_MUL;
        end
      end
      S_HIT_MUL:  state_nxt = S_HIT_WB;
      S_HIT_WB:   state_nxt = S_DIV_RUN;
      S_DIV_RUN: begin
        if (div_stat.done) begin
          state_nxt = S_START_WB;
        end
      end
      S_START_WB: state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    mul_sel_start = 1'b0;
    div_start     = 1'b0;
    hit_wb        = 1'b0;
    step_wb       = 1'b0;
    pos_wb        = 1'b0;
    case (state_r)
      S_HIT_WB: begin
        hit_wb    = 1'b1;
        div_start = 1'b1;
      end
      S_DIV_RUN: begin
        mul_sel_start = 1'b1;
        step_wb       = div_stat.done;
      end
      S_START_WB: pos_wb = 1'b1;
      default: ;
    endcase
  end

  // Pixel row decode. The texel row is the integer part of v truncated toward
  // zero, so a negative position is negated, shifted and negated back.
  assign pix_last = ({1'b0, row_counter_r} + 12'd1) >= {1'b0, h_eff};
  assign v_neg    = 40'd0 - v_position_r;
  assign pix_tv   = v_position_r[39] ? (TEX_BITS'(0) - v_neg[16 +: TEX_BITS])
                                     : v_position_r[16 +: TEX_BITS];

  always_comb begin
    if (row_counter_r < wall_first_row_r) begin
      pix_kind = KIND_CEILING;
    end else if (row_counter_r < wall_end_row_r) begin
      pix_kind = KIND_WALL;
    end else begin
      pix_kind = KIND_FLOOR;
    end
  end

  // Configuration and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= SCREEN_HEIGHT_RST;
      ceiling_color_r <= '0;
      floor_color_r   <= '0;
      crouch_offset_r <= '0;
      bonus_mode_r    <= 1'b0;
      state_r         <= S_IDLE;
      column_active_r <= 1'b0;
      row_counter_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[10:0];
          REG_CEILING_COLOR: ceiling_color_r <= cfg_wdata[23:0];
          REG_FLOOR_COLOR:   floor_color_r   <= cfg_wdata[23:0];
          REG_CROUCH_OFFSET: crouch_offset_r <= cfg_wdata[10:0];
          REG_BONUS_MODE:    bonus_mode_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      state_r <= state_nxt;
      if (setup_fire) begin
        column_active_r <= 1'b1;
        row_counter_r   <= '0;
      end else if (pix_fire) begin
        column_active_r <= !pix_last;
        row_counter_r   <= pix_last ? '0 : row_counter_r + ROW_W'(1);
      end
      if (pix_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Column payload registers.
  always_ff @(posedge clk) begin
    if (setup_fire) begin
      held_column_r    <= f_column;
      held_tid_r       <= tid_w;
      wall_first_row_r <= f_line_first;
      wall_end_row_r   <= f_line_last;
      dist_r           <= f_dist;
      dir_r            <= f_side ? f_dir_x : f_dir_y;
      pos_lo_r         <= f_side ? f_pos_x[15:0] : f_pos_y[15:0];
      mirror_r         <= (!f_side && dx_neg) || (f_side && dy_pos);
      lh_r             <= lh_eff;
      base_r           <= base_w;
    end
    if (hit_wb) begin
      held_tex_u_r <= mirror_r ? ~u_raw : u_raw;
    end
    if (step_wb) begin
      v_step_r <= div_quo;
    end
    if (pos_wb) begin
      v_position_r <= mul_p[39:0];
    end else if (pix_fire && (pix_kind == KIND_WALL)) begin
      v_position_r <= v_position_r + 40'(v_step_r);
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      out_kind_r  <= pix_kind;
      out_row_r   <= row_counter_r[9:0];
      out_col_r   <= held_column_r;
      out_last_r  <= pix_last;
      out_tid_r   <= (pix_kind == KIND_WALL) ? held_tid_r : 6'd0;
      out_tu_r    <= (pix_kind == KIND_WALL) ? 6'(held_tex_u_r) : 6'd0;
      out_tv_r    <= (pix_kind == KIND_WALL) ? 6'(pix_tv) : 6'd0;
      case (pix_kind)
        KIND_CEILING: out_color_r <= ceiling_color_r;
        KIND_FLOOR:   out_color_r <= floor_color_r;
        default:      out_color_r <= '0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_color_r, out_tv_r, out_tu_r, out_tid_r, out_col_r,
                       out_row_r};

  `RCWT_ASSERT_NEXT(a_setup_starts, clk, rst_n, rst_n && setup_fire, column_active_r && state_r == S_HIT_MUL)
  `RCWT_ASSERT_NEXT(a_pixel_result, clk, rst_n, rst_n && pix_fire, out_tvalid)
  `RCWT_ASSERT_NEXT(a_last_ends_column, clk, rst_n, rst_n && pix_fire && pix_last, !column_active_r && row_counter_r == '0)
  `RCWT_ASSERT_IMPL(a_wall_no_color, clk, rst_n, out_tvalid && out_tuser == KIND_WALL, out_color_r == '0)

endmodule

### tb/raycast_wall_column_texturer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for raycast_wall_column_texturer: a directed opening, then
// randomized columns under several register settings, checked by an in-bench predictor.
// Depends only on rcwt_pkg and the block's RTL.

module raycast_wall_column_texturer_tb import rcwt_pkg::*;;

  localparam int TEX           = 64;
  localparam int MAX_ROWS      = 1024;
  // A setup yields nothing, so idle waits leave this much slack for the setup sequence.
  localparam int SETTLE_CYCLES = 40;

  // Field order mirrors the stream: {opcode (tuser), tdata[157:0]}, column lowest.
  typedef struct packed {
    logic               opcode;
    logic [7:0]         cell_code;
    logic [15:0]        line_height;
    logic [10:0]        line_last;
    logic [10:0]        line_first;
    logic [23:0]        wall_dist;
    logic [21:0]        pos_y;
    logic [21:0]        pos_x;
    logic signed [15:0] ray_dir_y;
    logic signed [15:0] ray_dir_x;
    logic               hit_side;
    logic [10:0]        column;
  } ray_item_t;

  // Result layout: {tuser, tlast, tdata[62:0]}, row lowest.
  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [23:0] color;
    logic [5:0]  tex_v;
    logic [5:0]  tex_u;
    logic [5:0]  texture_id;
    logic [10:0] column;
    logic [9:0]  row;
  } pixel_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  raycast_wall_column_texturer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the configuration registers, kept in step with every write.
  logic [10:0]        sh_height  = SCREEN_HEIGHT_RST;
  logic [23:0]        sh_ceiling = '0;
  logic [23:0]        sh_floor   = '0;
  logic signed [10:0] sh_crouch  = '0;
  logic               sh_bonus   = 1'b0;

  // Predicted column state, as the block holds it after reset.
  logic        column_active   = 1'b0;
  logic [10:0] row_counter     = '0;
  logic [10:0] held_column     = '0;
  logic [5:0]  held_texture_id = '0;
  logic [5:0]  held_tex_u      = '0;
  logic [10:0] wall_first_row  = '0;
  logic [10:0] wall_end_row    = '0;
  logic [31:0] v_step          = '0;
  logic [39:0] v_position      = '0;

  ray_item_t items_to_send[$];
  pixel_t    expected_pixels[$];
  int        items_pushed = 0;
  int        items_taken  = 0;
  int        errors       = 0;

  // When a quiet flag is set, that side runs flat out with no idle cycles.
  bit        in_quiet  = 1'b0;
  bit        out_quiet = 1'b0;
  int        in_gap    = 0;
  int        out_wait  = 0;
  int        out_draw  = 0;

  logic [7:0] bonus_cells [7] = '{CELL_FIVE, CELL_DOT, CELL_COMMA, CELL_UNDER,
                                  CELL_AT, CELL_HASH, CELL_DOLLAR};

  ray_item_t send_item;
  ray_item_t taken_item;
  pixel_t    want_pixel;
  pixel_t    got_pixel;

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // A zero height behaves as one row; anything above the row limit is clamped.
  function automatic int eff_height();
    if (sh_height == 0) return 1;
    if (sh_height > MAX_ROWS) return MAX_ROWS;
    return sh_height;
  endfunction

  function automatic logic [5:0] pick_texture(logic side, longint dx, longint dy,
                                              logic [7:0] cell_val);
    logic [5:0] id;
    if (side == 1'b0) id = (dx > 0) ? TID_EAST : TID_WEST;
    else id = (dy < 0) ? TID_NORTH : TID_SOUTH;
    if (sh_bonus) begin
      case (cell_val)
        CELL_FIVE:   id = TID_SOUTH;
        CELL_DOT:    id = TID_DOT;
        CELL_COMMA:  id = TID_COMMA;
        CELL_UNDER:  id = TID_UNDER;
        CELL_AT:     id = TID_AT;
        CELL_HASH:   id = TID_HASH;
        CELL_DOLLAR: id = TID_DOLLAR;
        default:     if (side == 1'b1 && dy > 0) id = TID_WEST;
      endcase
    end
    return id;
  endfunction

  // Setup: latch the texture, the texture column and the vertical stepping.
  task automatic latch_column(input ray_item_t it);
    longint      dx, dy, wall_len, lh, lf, crouch, h, base;
    logic [63:0] hit;
    int          u;
    dx       = $signed(it.ray_dir_x);
    dy       = $signed(it.ray_dir_y);
    wall_len = it.wall_dist;
    lh       = it.line_height;
    lf       = it.line_first;
    crouch   = sh_crouch;
    h        = eff_height();
    held_column     = it.column;
    held_texture_id = pick_texture(it.hit_side, dx, dy, it.cell_code);
    // The hit point runs along the axis the grid line does not cross.
    if (it.hit_side == 1'b0) begin
      hit = wall_len * dy;
      hit = (hit >> 14) + it.pos_y;
    end else begin
      hit = wall_len * dx;
      hit = (hit >> 14) + it.pos_x;
    end
    u = (int'(hit[15:0]) * TEX) >> 16;
    if ((it.hit_side == 1'b0 && dx < 0) || (it.hit_side == 1'b1 && dy > 0))
      u = TEX - 1 - u;
    held_tex_u = u[5:0];
    if (lh == 0) lh = 1;
    v_step     = 32'((longint'(TEX) << 16) / lh);
    base       = lf - h / 2 + lh / 2 - crouch;
    v_position = 40'(base * longint'(v_step));
    wall_first_row = it.line_first;
    wall_end_row   = it.line_last;
    row_counter    = '0;
    column_active  = 1'b1;
  endtask

  // Pixel: one row of the active column, if there is one.
  task automatic next_pixel();
    pixel_t      p;
    int          r, h;
    logic [39:0] mag;
    logic [63:0] ip;
    if (column_active) begin
      r = row_counter;
      h = eff_height();
      p = '0;
      p.row    = row_counter[9:0];
      p.column = held_column;
      p.last   = (r + 1 >= h);
      if (row_counter < wall_first_row) begin
        p.kind  = KIND_CEILING;
        p.color = sh_ceiling;
      end else if (row_counter < wall_end_row) begin
        p.kind = KIND_WALL;
        // The integer part of a negative position truncates toward zero.
        if (v_position[39]) begin
          mag = -v_position;
          ip  = 64'd0 - (64'(mag) >> 16);
        end else begin
          ip = 64'(v_position) >> 16;
        end
        p.texture_id = held_texture_id;
        p.tex_u      = held_tex_u;
        p.tex_v      = 6'(ip & (TEX - 1));
        v_position   = v_position + v_step;
      end else begin
        p.kind  = KIND_FLOOR;
        p.color = sh_floor;
      end
      if (p.last) begin
        column_active = 1'b0;
        row_counter   = '0;
      end else begin
        row_counter = row_counter + 1'b1;
      end
      expected_pixels.push_back(p);
    end
  endtask

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Driver: each item waits out the gap drawn when the item before it went out.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (in_tvalid && !in_tready) begin
      // Hold the item until the block takes it.
    end else if (in_gap > 0) begin
      in_gap    <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (items_to_send.size() > 0) begin
      send_item = items_to_send.pop_front();
      in_tdata  <= IN_TDATA_W'(send_item[157:0]);
      in_tuser  <= send_item.opcode;
      in_tvalid <= 1'b1;
      in_gap    <= draw_wait(in_quiet);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: after each taken result, stall for a freshly drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= 0;
    end else if (out_tvalid && out_tready) begin
      out_draw    = draw_wait(out_quiet);
      out_wait   <= out_draw;
      out_tready <= (out_draw == 0);
    end else if (out_wait > 0) begin
      out_wait   <= out_wait - 1;
      out_tready <= (out_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on every accepted item, compare every accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        items_taken++;
        taken_item = {in_tuser, in_tdata[157:0]};
        if (taken_item.opcode == OP_SETUP) latch_column(taken_item);
        else next_pixel();
      end
      if (out_tvalid && out_tready) begin
        got_pixel = {out_tuser, out_tlast, out_tdata[62:0]};
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: row %0d column %0d", got_pixel.row, got_pixel.column);
          errors++;
        end else begin
          want_pixel = expected_pixels.pop_front();
          check_field("pixel_kind", want_pixel.kind, got_pixel.kind);
          check_field("row", want_pixel.row, got_pixel.row);
          check_field("out_column", want_pixel.column, got_pixel.column);
          check_field("texture_id", want_pixel.texture_id, got_pixel.texture_id);
          check_field("tex_u", want_pixel.tex_u, got_pixel.tex_u);
          check_field("tex_v", want_pixel.tex_v, got_pixel.tex_v);
          check_field("flat_color", want_pixel.color, got_pixel.color);
          check_field("last_row", want_pixel.last, got_pixel.last);
        end
      end
    end
  end

  task automatic push_item(input ray_item_t it);
    items_to_send.push_back(it);
    items_pushed++;
  endtask

  // A pixel item carries random noise in the fields it does not use.
  function automatic ray_item_t random_pixel();
    logic [159:0] noise;
    ray_item_t    it;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[158:0];
    it.opcode = OP_PIXEL;
    return it;
  endfunction

  // Setup fields lean toward rows and heights that fit a column of h rows,
  // with the full field ranges mixed in.
  function automatic ray_item_t random_setup(int h);
    ray_item_t it;
    int        pick;
    it = random_pixel();
    it.opcode = OP_SETUP;
    if ($urandom_range(0, 7) == 0) it.ray_dir_x = '0;
    if ($urandom_range(0, 7) == 0) it.ray_dir_y = '0;
    if ($urandom_range(0, 1) == 0) it.wall_dist = 24'($urandom_range(0, 1 << 17));
    if ($urandom_range(0, 4) != 0) it.line_first = 11'($urandom_range(0, h + 1));
    if ($urandom_range(0, 4) != 0) it.line_last = 11'($urandom_range(0, h + 1));
    pick = $urandom_range(0, 15);
    if (pick == 0) it.line_height = '0;
    else if (pick < 9) it.line_height = 16'($urandom_range(1, 2 * h + 4));
    if ($urandom_range(0, 1) == 0) it.cell_code = bonus_cells[$urandom_range(0, 6)];
    return it;
  endfunction

  // One column: a setup and, up to 64 rows, usually exactly as many pixels as rows.
  // Sometimes the column is cut short by the next setup, sometimes overrun by pixels
  // that find no column; taller ones get 1 to 600. Now and then a stray pixel comes first.
  task automatic push_column(input int h, inout int counted);
    int n, pick;
    if ($urandom_range(0, 19) == 0) push_item(random_pixel());
    push_item(random_setup(h));
    pick = $urandom_range(0, 9);
    if (h > 64) n = $urandom_range(1, 600);
    else if (pick < 7) n = h;
    else if (pick < 9) n = $urandom_range(0, h);
    else n = h + $urandom_range(1, 3);
    repeat (n) push_item(random_pixel());
    counted += 1 + ((n < h) ? n : h);
  endtask

  task automatic wait_idle();
    while (items_taken != items_pushed || expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SCREEN_HEIGHT: sh_height  = val[10:0];
      REG_CEILING_COLOR: sh_ceiling = val[23:0];
      REG_FLOOR_COLOR:   sh_floor   = val[23:0];
      REG_CROUCH_OFFSET: sh_crouch  = val[10:0];
      REG_BONUS_MODE:    sh_bonus   = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int height, input int ceiling, input int floor_rgb,
                            input int crouch, input int bonus);
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(11'(height)));
    write_reg(REG_CEILING_COLOR, CFG_DATA_W'(ceiling));
    write_reg(REG_FLOOR_COLOR, CFG_DATA_W'(floor_rgb));
    write_reg(REG_CROUCH_OFFSET, CFG_DATA_W'(11'(crouch)));
    write_reg(REG_BONUS_MODE, CFG_DATA_W'(1'(bonus)));
  endtask

  // Main sequence: directed corner cases under the reset defaults and a few
  // hand-picked settings, then random phases that sweep the register extremes.
  initial begin
    ray_item_t it;
    int        ph_height [8] = '{1, 16, 2047, 33, 8, 0, 1024, 24};
    int        ph_crouch [8] = '{512, -512, 0, 0, 200, -77, 511, 0};
    int        ph_budget [8] = '{200, 250, 550, 250, 200, 100, 150, 200};
    int        counted, ceiling, floor_rgb, crouch;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A pixel with no column is swallowed without a result.
    push_item(random_pixel());
    // Field extremes at the reset height of 600 rows, with a zero line height.
    it = random_setup(600);
    it.column = 11'h7FF;  it.hit_side = 1'b0;
    it.ray_dir_x = 16'sh8000;  it.ray_dir_y = 16'sh7FFF;
    it.pos_x = '1;  it.pos_y = '1;  it.wall_dist = '1;
    it.line_first = '0;  it.line_last = 11'd1024;  it.line_height = '0;
    it.cell_code = CELL_FIVE;
    push_item(it);
    repeat (3) push_item(random_pixel());
    // A new setup in mid column restarts at row zero.
    it.column = '0;  it.hit_side = 1'b1;
    it.ray_dir_x = 16'sh7FFF;  it.ray_dir_y = 16'sh8000;
    it.pos_x = '0;  it.pos_y = '0;  it.wall_dist = '0;
    it.line_first = 11'd1024;  it.line_last = '0;  it.line_height = 16'hFFFF;
    it.cell_code = 8'hFF;
    push_item(it);
    repeat (2) push_item(random_pixel());
    wait_idle();

    // Short column with bonus mode on: an ordinary cell on a horizontal line
    // with a positive y direction falls back to the west texture. The last
    // pixel finds the column already closed.
    set_config(4, 24'hFFFFFF, 0, -512, 1);
    it = random_setup(4);
    it.hit_side = 1'b1;  it.ray_dir_y = 16'sh2000;  it.cell_code = 8'h78;
    it.line_first = 11'd1;  it.line_last = 11'd3;  it.line_height = 16'd2;
    push_item(it);
    repeat (5) push_item(random_pixel());
    wait_idle();

    // The height shrinks below the current row: the next row ends the column.
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(20));
    it = random_setup(20);
    it.line_first = '0;  it.line_last = 11'd20;
    push_item(it);
    repeat (6) push_item(random_pixel());
    wait_idle();
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(3));
    repeat (2) push_item(random_pixel());
    wait_idle();

    // A zero height acts as a single row.
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(0));
    push_item(random_setup(1));
    repeat (2) push_item(random_pixel());
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      ceiling   = $urandom_range(0, 24'hFFFFFF);
      floor_rgb = $urandom_range(0, 24'hFFFFFF);
      if (ph == 0) begin
        ceiling   = 24'hFFFFFF;
        floor_rgb = 0;
      end else if (ph == 1) begin
        ceiling   = 0;
        floor_rgb = 24'hFFFFFF;
      end
      crouch = (ph >= 4) ? $urandom_range(0, 1024) - 512 : ph_crouch[ph];
      if (ph == 7) ph_height[ph] = $urandom_range(2, 48);
      set_config(ph_height[ph], ceiling, floor_rgb, crouch,
                 (ph == 7) ? $urandom_range(0, 1) : (ph + 1) % 2);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < ph_budget[ph]) push_column(eff_height(), counted);
      wait_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
